FILE: hw/rtl/assert_macros.svh
// Assertion macros for the RTL of the rank normaliser.
// Depends on a signal named clk and a signal named rst in the using scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
// Whenever cond holds, prop must hold in the same cycle.
`define ASSERT_SAME(label, cond, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
    else $error("assertion failed");
// Whenever cond holds, prop must hold in the next cycle.
`define ASSERT_NEXT(label, cond, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
    else $error("assertion failed");
`else
`define ASSERT_SAME(label, cond, prop)
`define ASSERT_NEXT(label, cond, prop)
`endif
`endif

FILE: hw/rtl/rn_pkg.sv
// Shared types and constants for the rank normaliser.
// No dependencies.
package rn_pkg;

  localparam int unsigned MAX_COUNT_DEF = 64;
  localparam int unsigned VALUE_W       = 32;
  localparam int unsigned RANK_W        = 6;
  // Index carried with a circulating value; wide enough for a store of MAX_COUNT_DEF values.
  localparam int unsigned IDX_W         = 6;

  typedef struct packed {
    logic init;   // copy own value into the circulating slot, clear the rank
    logic step;   // compare and rotate the circulating values by one cell
    logic shift;  // move ranks one cell towards the output
  } rn_ctrl_t;

  typedef struct packed {
    logic signed [VALUE_W-1:0] value;
    logic [IDX_W-1:0]          idx;
    logic                      valid;
  } rn_circ_t;

endpackage

FILE: hw/rtl/rn_ifs.sv
// Handshake interfaces for the input and result channels of the rank normaliser.
// Depends on rn_pkg.
interface rn_in_if;
  logic                              valid;
  logic                              ready;
  logic signed [rn_pkg::VALUE_W-1:0] value;
  logic                              last;
  modport source (output valid, value, last, input ready);
  modport sink (input valid, value, last, output ready);
endinterface

interface rn_out_if;
  logic                       valid;
  logic                       ready;
  logic [rn_pkg::RANK_W-1:0]  rank;
  logic                       last_result;
  logic                       overflow;
  modport source (output valid, rank, last_result, overflow, input ready);
  modport sink (input valid, rank, last_result, overflow, output ready);
endinterface

FILE: hw/rtl/rn_cell.sv
// One cell of the ranking chain: holds one stored value and its rank counter.
// Depends on rn_pkg.
module rn_cell #(
  parameter int unsigned INDEX = 0
) (
  input  logic                              clk,
  input  rn_pkg::rn_ctrl_t                  ctrl,
  input  logic                              wr_en,
  input  logic signed [rn_pkg::VALUE_W-1:0] wr_value,
  input  logic                              own_valid,
  input  rn_pkg::rn_circ_t                  circ_in,
  input  logic [rn_pkg::RANK_W-1:0]         rank_in,
  output rn_pkg::rn_circ_t                  circ,
  output logic [rn_pkg::RANK_W-1:0]         rank
);

  logic signed [rn_pkg::VALUE_W-1:0] value;
  logic                              hit;

  // A passing value ranks below ours if smaller, or equal and earlier.
  assign hit = circ.valid &&
               ((circ.value < value) ||
                ((circ.value == value) && (circ.idx < rn_pkg::IDX_W'(INDEX))));

  always_ff @(posedge clk) begin
    if (wr_en) begin
      value <= wr_value;
    end
    if (ctrl.init) begin
      circ.value <= value;
      circ.idx   <= rn_pkg::IDX_W'(INDEX);
      circ.valid <= own_valid;
      rank       <= '0;
    end else if (ctrl.step) begin
      circ <= circ_in;
      if (hit) begin
        rank <= rank + rn_pkg::RANK_W'(1);
      end
    end else if (ctrl.shift) begin
      rank <= rank_in;
    end
  end

endmodule

FILE: hw/rtl/rank_normalizer_top.sv
// Rank normaliser top level: a chain of ranking cells and its sequencer.
// Depends on rn_pkg, rn_ifs, rn_cell and assert_macros.svh.
//
// The block takes a list of signed 32-bit values on the values channel, one
// item per cycle, and stores them in arrival order, one per cell. The item
// with last set closes the list. The block then gives one item per stored
// value on the ranks channel, in arrival order: the value's rank, 0 for the
// smallest, with equal values ranked by arrival. last_result marks the final
// item of the list. Values beyond MAX_COUNT are dropped, and every result of
// such a list carries overflow.
//
// Sequence: after the last item is taken, a set-up step (S_INIT) and a
// compare pass (S_PASS) follow, in which every value circulates once round
// the ring of cells. Ranks then leave one per cycle from cell 0 while the
// ranks channel is ready; a stall simply holds the current result. The
// values channel is not ready from the last item until the final result is
// taken.
//
// Reset (synchronous, active high) empties the store and returns to loading.
`include "assert_macros.svh"

module rank_normalizer_top #(
  parameter int unsigned MAX_COUNT = rn_pkg::MAX_COUNT_DEF
) (
  input logic      clk,
  input logic      rst,
  rn_in_if.sink    values,
  rn_out_if.source ranks
);

  localparam int unsigned CW = $clog2(MAX_COUNT + 1);

  typedef enum logic [1:0] {S_LOAD, S_INIT, S_PASS, S_EMIT} state_t;

  state_t           state;
  logic [CW-1:0]    count;
  logic [CW-1:0]    pass_left;
  logic             dropped;
  logic             in_acc;
  logic             out_acc;
  rn_pkg::rn_ctrl_t ctrl;

  rn_pkg::rn_circ_t            circ_w [MAX_COUNT];
  logic [rn_pkg::RANK_W-1:0]   rank_w [MAX_COUNT];

  assign values.ready = (state == S_LOAD);
  assign in_acc       = values.valid && values.ready;
  assign ranks.valid  = (state == S_EMIT);
  assign out_acc      = ranks.valid && ranks.ready;

  // Results leave from cell 0; the remaining ranks move down the chain.
  assign ranks.rank        = rank_w[0];
  assign ranks.last_result = (count == CW'(1));
  assign ranks.overflow    = dropped;

  assign ctrl.init  = (state == S_INIT);
  assign ctrl.step  = (state == S_PASS);
  assign ctrl.shift = out_acc;

  for (genvar i = 0; i < MAX_COUNT; i++) begin : g_cell
    rn_cell #(.INDEX(i)) u_cell (
      .clk       (clk),
      .ctrl      (ctrl),
      .wr_en     (in_acc && (count == CW'(i))),
      .wr_value  (values.value),
      .own_valid (CW'(i) < count),
      .circ_in   (circ_w[(i == 0) ? MAX_COUNT - 1 : i - 1]),
      .rank_in   ((i == MAX_COUNT - 1) ? '0 : rank_w[(i + 1) % MAX_COUNT]),
      .circ      (circ_w[i]),
      .rank      (rank_w[i])
    );
  end

  // The sequencer: loading, a set-up state, the compare pass, emission.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_LOAD;
      count     <= '0;
      dropped   <= 1'b0;
      pass_left <= '0;
    end else begin
      case (state)
        S_LOAD: begin
          if (in_acc) begin
            if (count < CW'(MAX_COUNT)) begin
              count <= count + CW'(1);
            end else begin
              dropped <= 1'b1;
            end
            if (values.last) begin
              state <= S_INIT;
            end
          end
        end
        S_INIT: begin
          pass_left <= CW'(MAX_COUNT - 1);
          state     <= S_PASS;
        end
        S_PASS: begin
          if (pass_left == '0) begin
            state <= S_EMIT;
          end else begin
            pass_left <= pass_left - CW'(1);
          end
        end
        S_EMIT: begin
          if (out_acc) begin
            count <= count - CW'(1);
            if (count == CW'(1)) begin
              dropped <= 1'b0;
              state   <= S_LOAD;
            end
          end
        end
        default: begin
          state <= S_LOAD;
        end
      endcase
    end
  end

  `ASSERT_SAME(a_no_load_while_emit, ranks.valid, !values.ready)
  `ASSERT_SAME(a_emit_nonempty, ranks.valid, count != '0)
  `ASSERT_NEXT(a_back_to_load, out_acc && (count == CW'(1)), values.ready && (count == '0))
  `ASSERT_NEXT(a_drop_marks, in_acc && (count == CW'(MAX_COUNT)), dropped)

endmodule
